### hw/rtl/vssync_pkg.sv
`default_nettype none

package vssync_pkg;

   // Stream geometry
   localparam int PACKET_BYTES        = 164;
   localparam int PACKETS_PER_SEGMENT = 60;
   localparam int SEGMENTS_PER_FRAME  = 4;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int BPOS_W  = 8;
   localparam int PPOS_W  = 6;
   localparam int SPOS_W  = 2;
   localparam int TOTAL_W = 8;

   // Result tdata width, padded to whole bytes
   localparam int RSP_FIELDS_W = BYTE_W + BPOS_W + PPOS_W + SPOS_W + 3 + TOTAL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Header decode constants
   localparam logic [3:0]        DISCARD_NIBBLE = 4'hF;
   localparam logic [PPOS_W-1:0] HEADER_PACKET  = PPOS_W'(20);
   localparam logic [BYTE_W-1:0] HEADER_NUMBER  = BYTE_W'(20);
   localparam logic [3:0]        SYNC_SEGMENT   = 4'd1;
   localparam logic [3:0]        NULL_SEGMENT   = 4'd0;

   // Last positions
   localparam logic [BPOS_W-1:0] LAST_BYTE_POS   = BPOS_W'(PACKET_BYTES - 1);
   localparam logic [PPOS_W-1:0] LAST_PACKET_POS = PPOS_W'(PACKETS_PER_SEGMENT - 1);
   localparam logic [SPOS_W:0]   FRAME_SEGMENTS  = (SPOS_W+1)'(SEGMENTS_PER_FRAME);

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // One tagged result
   typedef struct packed {
      logic [BYTE_W-1:0]  byte_out;
      logic [BPOS_W-1:0]  byte_pos;
      logic [PPOS_W-1:0]  packet_pos;
      logic [SPOS_W-1:0]  segment_pos;
      logic               is_discard;
      logic               segment_end;
      logic               segment_kept;
      logic               frame_done;
      logic               resync_request;
      logic [TOTAL_W-1:0] resync_total;
   } rsp_fields_type;

endpackage

`default_nettype wire

### hw/rtl/vssync_track.sv
`default_nettype none

module vssync_track (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic                        csr_wdata,
   input  wire logic                        step,
   input  wire logic [vssync_pkg::BYTE_W-1:0] data_byte,
   output vssync_pkg::rsp_fields_type       result
);
   import vssync_pkg::*;

   logic                 assume_synced_ff;
   logic [BPOS_W-1:0]    byte_cnt_ff,   byte_cnt_in;
   logic [PPOS_W-1:0]    pkt_cnt_ff,    pkt_cnt_in;
   logic [SPOS_W-1:0]    seg_cnt_ff,    seg_cnt_in;
   logic                 first_found_ff, first_found_in;
   logic                 discard_ff,    discard_in;
   logic [BYTE_W-1:0]    head_ff,       head_in;
   logic [BYTE_W-1:0]    number_ff,     number_in;
   logic [TOTAL_W-1:0]   count_ff,      count_in;

   logic                 last_byte;
   logic                 seg_end;
   logic                 kept;
   logic                 done;
   logic                 resync;
   logic [3:0]           seg_num;
   logic [SPOS_W:0]      seg_inc;

   // Per-byte tagging and segment decision
   always_comb begin
      byte_cnt_in    = byte_cnt_ff;
      pkt_cnt_in     = pkt_cnt_ff;
      seg_cnt_in     = seg_cnt_ff;
      first_found_in = first_found_ff;
      count_in       = count_ff;
      kept           = 1'b0;
      done           = 1'b0;
      resync         = 1'b0;

      // a discard packet is only recognized in the first slot of a segment
      if (byte_cnt_ff == '0) begin
         discard_in = (pkt_cnt_ff == '0) && (data_byte[3:0] == DISCARD_NIBBLE);
      end else begin
         discard_in = discard_ff;
      end

      // latch the header of the reference packet
      head_in   = head_ff;
      number_in = number_ff;
      if (!discard_in && pkt_cnt_ff == HEADER_PACKET) begin
         if (byte_cnt_ff == BPOS_W'(0)) begin
            head_in = data_byte;
         end else if (byte_cnt_ff == BPOS_W'(1)) begin
            number_in = data_byte;
         end
      end

      last_byte = byte_cnt_ff >= LAST_BYTE_POS;
      seg_end   = !discard_in && last_byte && (pkt_cnt_ff >= LAST_PACKET_POS);
      seg_num   = head_in[7:4];
      seg_inc   = {1'b0, seg_cnt_ff} + (SPOS_W+1)'(1);

      // advance byte and packet positions
      if (last_byte) begin
         byte_cnt_in = '0;
         if (!discard_in) begin
            pkt_cnt_in = seg_end ? '0 : pkt_cnt_ff + PPOS_W'(1);
         end
      end else begin
         byte_cnt_in = byte_cnt_ff + BPOS_W'(1);
      end

      // keep, redo or resync at segment end
      if (seg_end) begin
         priority if (assume_synced_ff) begin
            kept = seg_num != NULL_SEGMENT;
         end else if (first_found_ff) begin
            kept = 1'b1;
         end else if (number_in != HEADER_NUMBER) begin
            resync = 1'b1;
            if (count_ff != TOTAL_MAX) begin
               count_in = count_ff + TOTAL_W'(1);
            end
         end else if (seg_num == SYNC_SEGMENT) begin
            kept           = 1'b1;
            first_found_in = 1'b1;
         end else begin
            // wrong segment number: redo the segment silently
            kept = 1'b0;
         end
         if (kept) begin
            if (seg_inc >= FRAME_SEGMENTS) begin
               done = 1'b1;
            end else begin
               seg_cnt_in = seg_inc[SPOS_W-1:0];
            end
         end
      end

      result.byte_out       = data_byte;
      result.byte_pos       = byte_cnt_ff;
      result.packet_pos     = pkt_cnt_ff;
      result.segment_pos    = seg_cnt_ff;
      result.is_discard     = discard_in;
      result.segment_end    = seg_end;
      result.segment_kept   = kept;
      result.frame_done     = done;
      result.resync_request = resync;
      result.resync_total   = count_in;

      // start a fresh frame after the last segment
      if (done) begin
         seg_cnt_in     = '0;
         first_found_in = 1'b0;
         count_in       = '0;
      end
   end

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         assume_synced_ff <= 1'b0;
      end else if (csr_we) begin
         assume_synced_ff <= csr_wdata;
      end
   end

   // Commit tracking state once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff    <= '0;
         pkt_cnt_ff     <= '0;
         seg_cnt_ff     <= '0;
         first_found_ff <= 1'b0;
         discard_ff     <= 1'b0;
         head_ff        <= '0;
         number_ff      <= '0;
         count_ff       <= '0;
      end else if (step) begin
         byte_cnt_ff    <= byte_cnt_in;
         pkt_cnt_ff     <= pkt_cnt_in;
         seg_cnt_ff     <= seg_cnt_in;
         first_found_ff <= first_found_in;
         discard_ff     <= discard_in;
         head_ff        <= head_in;
         number_ff      <= number_in;
         count_ff       <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/video_spi_segment_synchronizer.sv
// Channel  | Signals                          | Carries
// ---------+----------------------------------+----------------------------------------
// req      | req_tvalid/tready/tdata[7:0]     | data_byte
// rsp      | rsp_tvalid/tready/tdata/tuser/   | tagged byte; tuser = is_discard,
//          | tlast                            | tlast = segment_end
// csr      | csr_we, csr_wdata                | assume_synced
//
// One byte per cycle sustained while rsp is ready. A byte is held in the input register and
// is tagged on its way into the result register.
// Reset is synchronous and clears counters, header latches and the mode bit.
// A stall on rsp holds the result register; req keeps flowing until the input
// register is also occupied.
`default_nettype none

module video_spi_segment_synchronizer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic                              csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] data_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] byte_out, [15:8] byte_pos, [21:16] packet_pos, [23:22] segment_pos,
   // [24] segment_kept, [25] frame_done, [26] resync_request,
   // [34:27] resync_total, [39:35] zero
   output logic [vssync_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tuser,  // [0] is_discard
   output logic                                   rsp_tlast   // segment_end
);
   import vssync_pkg::*;

   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_data_ff;
   logic                 out_valid_ff;
   rsp_fields_type       out_ff;
   rsp_fields_type       result;
   logic                 advance;

   // Move the input byte forward when the result register is free or being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   vssync_track u_track (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .data_byte (in_data_ff),
      .result    (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   // Pack the result transaction
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.is_discard;
   assign rsp_tlast  = out_ff.segment_end;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_ff.resync_total, out_ff.resync_request,
                        out_ff.frame_done, out_ff.segment_kept, out_ff.segment_pos,
                        out_ff.packet_pos, out_ff.byte_pos, out_ff.byte_out};

endmodule

`default_nettype wire

### hw/rtl/vssync_checker.sv
`default_nettype none

module vssync_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [vssync_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                         rsp_tuser,
   input wire logic                         rsp_tlast
);
   import vssync_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // A completed frame is a kept segment end
   a_done_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tlast && rsp_tdata[24])
      else $error("frame done without kept segment end");

   // A resync request ends a segment that is not kept
   a_resync_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tlast && !rsp_tdata[24])
      else $error("resync request outside a dropped segment end");

   // Discard bytes never close a segment and stay inside a packet
   a_discard: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && (rsp_tdata[15:8] <= LAST_BYTE_POS))
      else $error("discard byte closed a segment");

endmodule

bind video_spi_segment_synchronizer vssync_checker u_vssync_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import vssync_pkg::*;

   typedef rsp_fields_type byte_tag_type;

   localparam int STALL_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic                  csr_wdata  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   video_spi_segment_synchronizer u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Byte stream waiting to be sent and the tags expected back
   logic [7:0]   pending_bytes[$];
   byte_tag_type expected_tags[$];

   bit idle_on      = 1'b1;
   bit req_fire     = 1'b0;
   int send_gap     = 0;
   int hold_gap     = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   // Tagger state: position counters, header latches, hunt status
   logic [BPOS_W-1:0]  pos_byte      = '0;
   logic [PPOS_W-1:0]  pos_packet    = '0;
   logic [SPOS_W-1:0]  pos_segment   = '0;
   logic               first_seen    = 1'b0;
   logic               in_discard_pkt = 1'b0;
   logic [BYTE_W-1:0]  head_byte     = '0;
   logic [BYTE_W-1:0]  number_byte   = '0;
   logic [TOTAL_W-1:0] resync_tally  = '0;
   logic               synced_mode   = 1'b0;

   // Stream position as seen by the stimulus generator
   int gen_byte    = 0;
   int gen_packet  = 0;
   bit gen_discard = 1'b0;

   // Tag one byte and advance the segment bookkeeping
   function automatic byte_tag_type tag_byte(input logic [7:0] b);
      byte_tag_type t;
      logic         last_b;
      logic [3:0]   seg_num;
      t             = '0;
      t.byte_out    = b;
      t.byte_pos    = pos_byte;
      t.packet_pos  = pos_packet;
      t.segment_pos = pos_segment;
      if (pos_byte == 0)
         in_discard_pkt = (pos_packet == 0) && (b[3:0] == DISCARD_NIBBLE);
      // latch the header of the check packet
      if (!in_discard_pkt && pos_packet == HEADER_PACKET) begin
         if (pos_byte == 0)
            head_byte = b;
         else if (pos_byte == 1)
            number_byte = b;
      end
      last_b = (int'(pos_byte) + 1 >= PACKET_BYTES);
      t.segment_end = !in_discard_pkt && last_b &&
                      (int'(pos_packet) + 1 >= PACKETS_PER_SEGMENT);
      if (last_b) begin
         pos_byte = '0;
         if (!in_discard_pkt)
            pos_packet = t.segment_end ? '0 : pos_packet + 1'b1;
      end else begin
         pos_byte = pos_byte + 1'b1;
      end
      // decide keep, redo or resync at segment end
      if (t.segment_end) begin
         seg_num = head_byte[7:4];
         if (synced_mode) begin
            t.segment_kept = (seg_num != NULL_SEGMENT);
         end else if (first_seen) begin
            t.segment_kept = 1'b1;
         end else if (number_byte != HEADER_NUMBER) begin
            t.resync_request = 1'b1;
            if (resync_tally != TOTAL_MAX)
               resync_tally = resync_tally + 1'b1;
         end else if (seg_num == SYNC_SEGMENT) begin
            t.segment_kept = 1'b1;
            first_seen     = 1'b1;
         end
         if (t.segment_kept) begin
            if (int'(pos_segment) + 1 >= SEGMENTS_PER_FRAME)
               t.frame_done = 1'b1;
            else
               pos_segment = pos_segment + 1'b1;
         end
      end
      t.is_discard   = in_discard_pkt;
      t.resync_total = resync_tally;
      // restart the frame once complete
      if (t.frame_done) begin
         pos_segment  = '0;
         first_seen   = 1'b0;
         resync_tally = '0;
      end
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Queue one byte; return 1 when it closes a segment
   function automatic bit push_byte(input logic [7:0] b);
      bit seg_over;
      seg_over = 1'b0;
      pending_bytes.push_back(b);
      if (gen_byte == 0)
         gen_discard = (gen_packet == 0) && (b[3:0] == DISCARD_NIBBLE);
      if (gen_byte + 1 >= PACKET_BYTES) begin
         gen_byte = 0;
         if (!gen_discard) begin
            seg_over   = (gen_packet + 1 >= PACKETS_PER_SEGMENT);
            gen_packet = seg_over ? 0 : gen_packet + 1;
         end
      end else begin
         gen_byte++;
      end
      return seg_over;
   endfunction

   // Queue up to count bytes, stopping early at a segment end, with a chosen
   // check-packet header
   task automatic push_segment(input logic [3:0] seg_num, input logic [7:0] number,
                               input int discards, input int count);
      logic [7:0] b;
      bit         closed;
      int         sent;
      closed = 1'b0;
      sent   = 0;
      while (!closed && sent < count) begin
         b = 8'($urandom);
         if (gen_byte == 0 && gen_packet == 0) begin
            if (discards > 0) begin
               b[3:0] = DISCARD_NIBBLE;
               discards--;
            end else if (b[3:0] == DISCARD_NIBBLE) begin
               b[0] = 1'b0;
            end
         end else if (gen_packet == int'(HEADER_PACKET)) begin
            if (gen_byte == 0)
               b[7:4] = seg_num;
            else if (gen_byte == 1)
               b = number;
         end
         closed = push_byte(b);
         sent++;
      end
   endtask

   function automatic logic [3:0] pick_segment_number();
      case ($urandom_range(0, 9))
         0, 1:    return NULL_SEGMENT;
         2, 3, 4: return SYNC_SEGMENT;
         5, 6:    return 4'($urandom_range(2, 3));
         default: return 4'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_packet_number();
      if ($urandom_range(0, 9) < 6)
         return HEADER_NUMBER;
      return 8'($urandom);
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tags.size() != 0)
         @(negedge clock);
   endtask

   // Change mode only with the pipeline empty
   task automatic set_mode(input bit synced);
      wait_drained();
      @(negedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= synced;
      synced_mode = synced;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Sender: hold a transaction until taken, insert idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 16);
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_tdata  <= pending_bytes.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         hold_gap = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      byte_tag_type          want;
      logic [RSP_DATA_W-1:0] got;
      if (reset) begin
         req_fire     <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_tags.push_back(tag_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_tags.size() == 0) begin
               $error("result transaction with no byte awaiting it: tdata=%h", got);
               mismatch_count++;
            end else begin
               want = expected_tags.pop_front();
               check_field("byte_out", want.byte_out, got[7:0]);
               check_field("byte_pos", want.byte_pos, got[15:8]);
               check_field("packet_pos", 8'(want.packet_pos), 8'(got[21:16]));
               check_field("segment_pos", 8'(want.segment_pos), 8'(got[23:22]));
               check_field("segment_kept", 8'(want.segment_kept), 8'(got[24]));
               check_field("frame_done", 8'(want.frame_done), 8'(got[25]));
               check_field("resync_request", 8'(want.resync_request), 8'(got[26]));
               check_field("resync_total", want.resync_total, got[34:27]);
               check_field("pad", 8'h00, 8'(got[RSP_DATA_W-1:RSP_FIELDS_W]));
               check_field("is_discard", 8'(want.is_discard), 8'(rsp_tuser));
               check_field("segment_end", 8'(want.segment_end), 8'(rsp_tlast));
            end
         end
         // watchdog on transaction progress
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hunting from reset: a run of discard packets
      set_mode(1'b0);
      void'(push_byte(8'hFF));
      void'(push_byte(8'h00));
      void'(push_byte(8'h7F));
      void'(push_byte(8'h80));
      void'(push_byte(8'h01));
      void'(push_byte(8'hFE));
      push_segment(NULL_SEGMENT, 8'd7, 2, 350);

      // Synced: the counters carry on across the mode change
      set_mode(1'b1);
      push_segment(NULL_SEGMENT, HEADER_NUMBER, 1, 200);

      // Back to hunting mid-segment
      set_mode(1'b0);
      push_segment(SYNC_SEGMENT, 8'hFF, 0, 200);

      // Random phases; last one runs without idling
      for (int ph = 0; ph < 6; ph++) begin
         set_mode(1'($urandom_range(0, 1)));
         idle_on = (ph < 5) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 40)) void'(push_byte(8'($urandom)));
         push_segment(pick_segment_number(), pick_packet_number(),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
                      $urandom_range(80, 140));
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
